[design/longest_prefix_route_table_macros.svh]
// Assertion macros used by the route table design file.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lprt_pkg.sv]
// Types, constants and helper functions of the longest prefix route table.
package lprt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int IP_W            = 32;
  localparam int PORT_W          = 2;
  localparam int METRIC_W        = 16;
  localparam int PLEN_W          = 6;
  localparam int CMD_W           = 2;
  localparam int STATUS_W        = 2;

  localparam logic [PORT_W-1:0] NO_ROUTE_RESET = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]     network;
    logic [IP_W-1:0]     mask;
    logic [PLEN_W-1:0]   plen;
    logic [PORT_W-1:0]   port;
    logic [METRIC_W-1:0] cost;
  } entry_t;

  // Population count of a 32-bit mask as a five-level adder tree.
  function automatic logic [PLEN_W-1:0] count_ones(logic [IP_W-1:0] v);
    logic [IP_W-1:0] a;
    logic [IP_W-1:0] b;
    logic [IP_W-1:0] c;
    logic [IP_W-1:0] d;
    logic [IP_W-1:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[PLEN_W-1:0];
  endfunction

endpackage

[design/lprt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/longest_prefix_route_table.sv]
// IPv4 route table with add, delete and longest prefix lookup. One transaction is worked
// on at a time: an add or an unused command goes through S_RUN and S_FINISH before the next
// transaction can be accepted, and a delete or lookup goes through S_SCAN, which reads each
// of the slots used so far (at most MAX_ENTRIES) in turn, and then S_FINISH. The scan is
// serial because the table sits in a RAM with one read port and a single compare unit checks
// one entry per cycle. The result is held in an output register, so a stalled result does not
// stop the next transaction from starting; a later result waits in S_FINISH until that
// register has been taken.
`include "longest_prefix_route_table_macros.svh"

module longest_prefix_route_table #(
  parameter int MAX_ENTRIES = lprt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [lprt_pkg::PORT_W-1:0]   cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lprt_pkg::CMD_W-1:0]    in_command,
  input  logic [lprt_pkg::IP_W-1:0]     in_address,
  input  logic [lprt_pkg::IP_W-1:0]     in_mask,
  input  logic [lprt_pkg::PORT_W-1:0]   in_port,
  input  logic [lprt_pkg::METRIC_W-1:0] in_metric,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lprt_pkg::STATUS_W-1:0] out_status,
  output logic [lprt_pkg::PORT_W-1:0]   out_route_port
);

  import lprt_pkg::*;

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W = $bits(entry_t);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [IP_W-1:0]       addr_r;
  logic [IP_W-1:0]       mask_r;
  logic [PORT_W-1:0]     port_r;
  logic [METRIC_W-1:0]   metric_r;

  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]      eval_idx_r, eval_idx_nxt;
  logic                  found_r, found_nxt;
  logic [PLEN_W-1:0]     best_len_r, best_len_nxt;
  logic [METRIC_W-1:0]   best_cost_r, best_cost_nxt;
  logic [PORT_W-1:0]     best_port_r, best_port_nxt;
  logic                  del_hit_r, del_hit_nxt;
  logic [IDX_W-1:0]      del_idx_r, del_idx_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [PORT_W-1:0]     res_port_r, res_port_nxt;
  logic [CNT_W-1:0]      entries_used_r, entries_used_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [PORT_W-1:0]     no_route_port_r;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [PORT_W-1:0]     out_route_port_r, out_route_port_nxt;

  logic                  in_accept;
  logic                  table_full;
  logic                  ram_we;
  entry_t                ram_wentry;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_entry;
  logic [IP_W-1:0]       cmp_key;
  logic                  key_eq;
  logic                  entry_live;
  logic                  better;

  lprt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entries_used_r[IDX_W-1:0]),
    .wdata (ram_wentry),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_accept  = in_valid && !in_stall;
  assign table_full = (entries_used_r == CNT_W'(MAX_ENTRIES));
  assign rd_entry   = ram_rdata;

  assign ram_wentry.network = addr_r & mask_r;
  assign ram_wentry.mask    = mask_r;
  assign ram_wentry.plen    = count_ones(mask_r);
  assign ram_wentry.port    = port_r;
  assign ram_wentry.cost    = metric_r;

  // Shared compare unit: lookups mask the address with the stored mask, deletes with
  // their own mask.
  assign cmp_key    = (cmd_r == CMD_LOOKUP) ? (addr_r & rd_entry.mask) : (addr_r & mask_r);
  assign key_eq     = (cmp_key == rd_entry.network);
  assign entry_live = valid_r[eval_idx_r];
  assign better     = !found_r || (rd_entry.plen > best_len_r) ||
                      ((rd_entry.plen == best_len_r) && (rd_entry.cost < best_cost_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      idx_r            <= '0;
      rd_pend_r        <= 1'b0;
      eval_idx_r       <= '0;
      found_r          <= 1'b0;
      best_len_r       <= '0;
      best_cost_r      <= '0;
      best_port_r      <= '0;
      del_hit_r        <= 1'b0;
      del_idx_r        <= '0;
      res_status_r     <= STATUS_OK;
      res_port_r       <= '0;
      entries_used_r   <= '0;
      valid_r          <= '0;
      no_route_port_r  <= NO_ROUTE_RESET;
      out_valid_r      <= 1'b0;
      out_status_r     <= STATUS_OK;
      out_route_port_r <= '0;
    end else begin
      state_r          <= state_nxt;
      idx_r            <= idx_nxt;
      rd_pend_r        <= rd_pend_nxt;
      eval_idx_r       <= eval_idx_nxt;
      found_r          <= found_nxt;
      best_len_r       <= best_len_nxt;
      best_cost_r      <= best_cost_nxt;
      best_port_r      <= best_port_nxt;
      del_hit_r        <= del_hit_nxt;
      del_idx_r        <= del_idx_nxt;
      res_status_r     <= res_status_nxt;
      res_port_r       <= res_port_nxt;
      entries_used_r   <= entries_used_nxt;
      valid_r          <= valid_nxt;
      out_valid_r      <= out_valid_nxt;
      out_status_r     <= out_status_nxt;
      out_route_port_r <= out_route_port_nxt;
      if (cfg_write_en) begin
        no_route_port_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r    <= cmd_t'(in_command);
      addr_r   <= in_address;
      mask_r   <= in_mask;
      port_r   <= in_port;
      metric_r <= in_metric;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    rd_pend_nxt        = 1'b0;
    eval_idx_nxt       = eval_idx_r;
    found_nxt          = found_r;
    best_len_nxt       = best_len_r;
    best_cost_nxt      = best_cost_r;
    best_port_nxt      = best_port_r;
    del_hit_nxt        = del_hit_r;
    del_idx_nxt        = del_idx_r;
    res_status_nxt     = res_status_r;
    res_port_nxt       = res_port_r;
    entries_used_nxt   = entries_used_r;
    valid_nxt          = valid_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_status_nxt     = out_status_r;
    out_route_port_nxt = out_route_port_r;
    ram_we             = 1'b0;
    in_stall           = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          del_hit_nxt = 1'b0;
          if ((in_command == CMD_DELETE) || (in_command == CMD_LOOKUP)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end

      S_RUN: begin
        res_status_nxt = STATUS_OK;
        res_port_nxt   = '0;
        unique case (cmd_r)
          CMD_ADD: begin
            if (table_full) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              ram_we           = 1'b1;
              valid_nxt[entries_used_r[IDX_W-1:0]] = 1'b1;
              entries_used_nxt = entries_used_r + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
        state_nxt = S_FINISH;
      end

      S_SCAN: begin
        if (idx_r < entries_used_r) begin
          rd_pend_nxt  = 1'b1;
          eval_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
        end
        if (rd_pend_r) begin
          if (cmd_r == CMD_LOOKUP) begin
            if (entry_live && key_eq && better) begin
              found_nxt     = 1'b1;
              best_len_nxt  = rd_entry.plen;
              best_cost_nxt = rd_entry.cost;
              best_port_nxt = rd_entry.port;
            end
          end else if (entry_live && key_eq && (rd_entry.mask == mask_r) && !del_hit_r) begin
            del_hit_nxt = 1'b1;
            del_idx_nxt = eval_idx_r;
          end
        end else if (!(idx_r < entries_used_r)) begin
          if (cmd_r == CMD_LOOKUP) begin
            res_status_nxt = STATUS_OK;
            res_port_nxt   = found_r ? best_port_r : no_route_port_r;
          end else begin
            res_status_nxt = del_hit_r ? STATUS_OK : STATUS_NOT_FOUND;
            res_port_nxt   = '0;
          end
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = res_status_r;
          out_route_port_nxt = res_port_r;
          if ((cmd_r == CMD_DELETE) && del_hit_r) begin
            valid_nxt[del_idx_r] = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_route_port = out_route_port_r;

  `LPRT_ASSERT_SAME(a_used_bound, clk, rst_n, 1'b1, entries_used_r <= CNT_W'(MAX_ENTRIES), "slot count beyond table depth")
  `LPRT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_accept, state_r != S_IDLE, "accepted transaction not started")
  `LPRT_ASSERT_NEXT(a_add_count, clk, rst_n, (state_r == S_RUN) && (cmd_r == CMD_ADD) && !table_full, entries_used_r == CNT_W'($past(entries_used_r) + CNT_W'(1)), "add did not take one slot")
  `LPRT_ASSERT_SAME(a_err_port, clk, rst_n, out_valid_r && (out_status_r != STATUS_OK), out_route_port_r == '0, "error result carries a port")

endmodule
